// ===== rtl/utf8_to_latin1_transcoder_defines.svh =====
// assertion macros for the utf-8 to latin-1 transcoder
// used by the top level only, no other dependencies
`ifndef UTF8_TO_LATIN1_TRANSCODER_DEFINES_SVH
`define UTF8_TO_LATIN1_TRANSCODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define U2L_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define U2L_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/u2l_pkg.sv =====
// shared types, constants and character functions of the utf-8 to latin-1 transcoder
// no dependencies
`default_nettype none

package u2l_pkg;

   localparam int MaxChars = 4;
   localparam int CountW   = $clog2(MaxChars + 1);
   localparam int IdxW     = $clog2(MaxChars);
   localparam int CodeW    = 21;

   localparam logic [CodeW-1:0] EuroCode = 21'h0020AC;
   localparam logic [7:0]       EuroByte = 8'h80;

   // cp1252 code points for bytes 0x80..0x9f, zero where undefined
   localparam logic [15:0] WinHigh [0:31] = '{
      16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
      16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
   };

   typedef struct packed {
      logic [7:0] latin;
      logic       has;
   } u2l_char_type;

   typedef struct packed {
      u2l_char_type [MaxChars-1:0] chars;
      logic [CountW-1:0]           count;
      logic                        done;
   } u2l_batch_type;

   typedef struct packed {
      logic [7:0]       lead;
      logic [1:0]       hcount;
      logic [1:0]       need;
      logic [CodeW-1:0] partial;
   } u2l_state_type;

   // latin-1 filter: euro sign maps to 0x80, above 0xff is deleted
   function automatic u2l_char_type put_code(input logic [CodeW-1:0] cp);
      u2l_char_type r;
      r = '0;
      if (cp == EuroCode) begin
         r.latin = EuroByte;
         r.has   = 1'b1;
      end else if (cp[CodeW-1:8] == '0) begin
         r.latin = cp[7:0];
         r.has   = 1'b1;
      end
      return r;
   endfunction

   // a byte taken alone, through the cp1252 table for 0x80..0x9f
   function automatic u2l_char_type put_lone(input logic [7:0] c);
      logic [15:0]      w;
      logic [CodeW-1:0] cp;
      w  = WinHigh[c[4:0]];
      cp = {{(CodeW-8){1'b0}}, c};
      if (c[7:5] == 3'b100 && w != 16'h0000) begin
         cp = {{(CodeW-16){1'b0}}, w};
      end
      return put_code(cp);
   endfunction

   // continuation bytes needed after a lead byte, zero if not a lead
   function automatic logic [1:0] lead_need(input logic [7:0] c);
      logic [1:0] n;
      n = 2'd0;
      if (c[7:5] == 3'b110) begin
         n = 2'd1;
      end else if (c[7:4] == 4'b1110) begin
         n = 2'd2;
      end else if (c[7:3] == 5'b11110) begin
         n = 2'd3;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8_to_latin1_transcoder.sv =====
// utf-8 to latin-1 transcoder, top level; depends on u2l_pkg, u2l_decode, u2l_outbuf
// results are registered: each appears in the cycle after the input transaction that causes it
// throughput: one input byte per cycle while the result stream is ready and each byte gives at most
//   one result; a byte that breaks a sequence gives up to four results and holds the input until
//   the last of them is sent, since the result register sends one transaction a cycle while ready
// reset: synchronous, active high; clears the sequence state and empties the result register
`default_nettype none
`include "utf8_to_latin1_transcoder_defines.svh"

module utf8_to_latin1_transcoder import u2l_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   // input stream: one raw text byte per transaction
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [7:0]  req_tdata,   // [7:0] text_byte
   input  wire        req_tlast,   // end_of_text
   // result stream: one latin-1 character per transaction
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] latin_byte
   output logic [1:0] rsp_tuser,   // [0] has_byte, [1] text_done
   output logic       rsp_tlast    // run_last
);

   u2l_batch_type batch;
   u2l_state_type seq_state;
   logic          req_fire;
   logic          has_byte;
   logic          text_done;

   // a new byte is taken whenever the result register is empty or finishing
   assign req_fire = req_tvalid && req_tready;

   // decode stage: sequence state plus combinational expansion into a batch
   u2l_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .accept      (req_fire),
      .batch       (batch),
      .state       (seq_state)
   );

   // result register: batch drains one character per transaction
   u2l_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .batch      (batch),
      .load       (req_fire),
      .in_ready   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .latin_byte (rsp_tdata),
      .has_byte   (has_byte),
      .run_last   (rsp_tlast),
      .text_done  (text_done)
   );

   assign rsp_tuser = {text_done, has_byte};

   // end of text always leaves no sequence open
   `U2L_ASSERT_NEXT(a_end_closes, clock, reset, req_fire && req_tlast, seq_state.need == 2'd0, "sequence still open after end of text")

   // an input is only taken when no earlier result beyond the current one waits
   `U2L_ASSERT_NOW(a_no_overrun, clock, reset, req_fire, !rsp_tvalid || (rsp_tready && rsp_tlast), "input taken while results still pending")

   // the text end marker only rides on the last result of a run
   `U2L_ASSERT_NOW(a_done_is_last, clock, reset, rsp_tvalid && text_done, rsp_tlast, "text_done without run_last")

   // a deleted character carries a zero byte
   `U2L_ASSERT_NOW(a_deleted_zero, clock, reset, rsp_tvalid && !has_byte, rsp_tdata == 8'h00, "deleted character with nonzero byte")

endmodule

`default_nettype wire

// ===== rtl/u2l_decode.sv =====
// sequence state and single-pass decode of one text byte into a batch of characters
// depends on u2l_pkg
`default_nettype none

module u2l_decode import u2l_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  wire [7:0]     text_byte,
   input  wire           end_of_text,
   input  wire           accept,
   output u2l_batch_type batch,
   output u2l_state_type state
);

   u2l_state_type state_ff, state_in;
   logic [7:0]    cont_ff [2];
   logic          cont_we;
   logic          cont_idx;
   logic [1:0]    need_c;
   logic [CodeW-1:0] new_part;
   logic          do_exam;
   logic [CountW-1:0] n;
   u2l_char_type [MaxChars-1:0] chars;

   assign need_c   = lead_need(text_byte);
   assign new_part = {state_ff.partial[CodeW-7:0], text_byte[5:0]};

   always_comb begin
      state_in = state_ff;
      cont_we  = 1'b0;
      cont_idx = state_ff.hcount[0];
      do_exam  = 1'b0;
      n        = '0;
      chars    = '0;

      if (state_ff.need != 2'd0) begin
         if (text_byte[7:6] == 2'b10) begin
            if ({1'b0, state_ff.hcount} + 3'd1 >= {1'b0, state_ff.need}) begin
               // sequence complete
               chars[n[IdxW-1:0]] = put_code(new_part);
               n = n + 1'b1;
               state_in = '0;
            end else if (end_of_text) begin
               // text ends inside the sequence: flush, then this byte alone
               chars[n[IdxW-1:0]] = put_lone(state_ff.lead);
               n = n + 1'b1;
               if (state_ff.hcount > 2'd0) begin
                  chars[n[IdxW-1:0]] = put_lone(cont_ff[0]);
                  n = n + 1'b1;
               end
               if (state_ff.hcount > 2'd1) begin
                  chars[n[IdxW-1:0]] = put_lone(cont_ff[1]);
                  n = n + 1'b1;
               end
               chars[n[IdxW-1:0]] = put_lone(text_byte);
               n = n + 1'b1;
               state_in = '0;
            end else begin
               cont_we          = 1'b1;
               state_in.hcount  = state_ff.hcount + 2'd1;
               state_in.partial = new_part;
            end
         end else begin
            // sequence broken: flush held bytes, then examine this one
            chars[n[IdxW-1:0]] = put_lone(state_ff.lead);
            n = n + 1'b1;
            if (state_ff.hcount > 2'd0) begin
               chars[n[IdxW-1:0]] = put_lone(cont_ff[0]);
               n = n + 1'b1;
            end
            if (state_ff.hcount > 2'd1) begin
               chars[n[IdxW-1:0]] = put_lone(cont_ff[1]);
               n = n + 1'b1;
            end
            state_in = '0;
            do_exam  = 1'b1;
         end
      end else begin
         do_exam = 1'b1;
      end

      if (do_exam) begin
         if (!text_byte[7]) begin
            chars[n[IdxW-1:0]] = put_code({{(CodeW-8){1'b0}}, text_byte});
            n = n + 1'b1;
         end else if (need_c != 2'd0 && !end_of_text) begin
            state_in.lead    = text_byte;
            state_in.hcount  = 2'd0;
            state_in.need    = need_c;
            state_in.partial = {{(CodeW-8){1'b0}}, text_byte & (8'h7F >> need_c)};
         end else begin
            chars[n[IdxW-1:0]] = put_lone(text_byte);
            n = n + 1'b1;
         end
      end

      if (end_of_text) begin
         // empty result carries the end marker
         if (n == '0) begin
            chars[0] = '0;
            n = n + 1'b1;
         end
         state_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && cont_we) begin
         cont_ff[cont_idx] <= text_byte;
      end
   end

   assign batch.chars = chars;
   assign batch.count = n;
   assign batch.done  = end_of_text;
   assign state       = state_ff;

endmodule

`default_nettype wire

// ===== rtl/u2l_outbuf.sv =====
// result register holding one batch of characters, sent one transaction per cycle while the receiver is ready
// depends on u2l_pkg
`default_nettype none

module u2l_outbuf import u2l_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  wire u2l_batch_type batch,
   input  wire           load,
   output logic          in_ready,
   output logic          out_valid,
   input  wire           out_ready,
   output logic [7:0]    latin_byte,
   output logic          has_byte,
   output logic          run_last,
   output logic          text_done
);

   u2l_char_type [MaxChars-1:0] chars_ff, chars_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic              done_ff, done_in;
   logic              last;
   logic              out_fire;
   u2l_char_type      cur;

   assign cur       = chars_ff[idx_ff];
   assign out_valid = (count_ff != '0);
   assign last      = (CountW'(idx_ff) + CountW'(1) == count_ff);
   assign out_fire  = out_valid && out_ready;
   assign in_ready  = (count_ff == '0) || (out_fire && last);

   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      done_in  = done_ff;
      if (out_fire) begin
         if (last) begin
            count_in = '0;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (load && batch.count != '0) begin
         chars_in = batch.chars;
         count_in = batch.count;
         idx_in   = '0;
         done_in  = batch.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      done_ff  <= done_in;
   end

   assign latin_byte = cur.latin;
   assign has_byte   = cur.has;
   assign run_last   = last;
   assign text_done  = last && done_ff;

endmodule

`default_nettype wire
